// ----- sv/rgbhsv_pkg.sv -----
// Package for the RGB to HSV converter: widths, constants and the
// transaction and job structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rgbhsv_pkg;

    localparam int CHANNEL_BITS    = 16;
    localparam int HUE_FRAC_BITS   = 6;

    localparam int SIXTY_UNITS     = 60 << HUE_FRAC_BITS;
    localparam int FULL_TURN_UNITS = 360 << HUE_FRAC_BITS;
    localparam int SIXTY_W         = $clog2(SIXTY_UNITS + 1);
    localparam int HUE_W           = $clog2(FULL_TURN_UNITS);
    localparam int HUE_QW          = $clog2(5 * SIXTY_UNITS);
    localparam int QUO_W           = (CHANNEL_BITS > HUE_QW) ? CHANNEL_BITS : HUE_QW;
    localparam int NUM_W           = CHANNEL_BITS + QUO_W;
    localparam int SECT_W          = CHANNEL_BITS + 3;
    localparam int QDEPTH          = 2;
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int QCNT_W          = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0]        hue;
        logic                    hue_undefined;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] hi;
        logic [CHANNEL_BITS-1:0] delta;
        logic [SECT_W-1:0]       num;
        logic                    neg;
        logic                    undef;
    } t_job;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] hi;
        logic                    neg;
        logic                    undef;
    } t_side;

endpackage
`default_nettype wire

// ----- sv/rgbhsv_front.sv -----
// Front end: accepts a pixel, finds max, min and sector, builds the hue
// numerator and hands a job to the queue. Depends on rgbhsv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsv_front import rgbhsv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_take,
    input  t_pixel i_pixel,
    input  logic   i_q_ready,
    output logic   o_busy,
    output logic   o_push,
    output t_job   o_job
);

    logic                    r_valid;
    logic                    n_valid;
    t_job                    r_job;
    t_job                    n_job;
    logic [CHANNEL_BITS-1:0] hi_val;
    logic [CHANNEL_BITS-1:0] lo_val;
    logic [CHANNEL_BITS-1:0] dlt;
    logic [SECT_W-1:0]       red_x;
    logic [SECT_W-1:0]       grn_x;
    logic [SECT_W-1:0]       blu_x;
    logic [SECT_W-1:0]       dlt_x;

    always_comb begin
        hi_val = i_pixel.red;
        if (i_pixel.green > hi_val) hi_val = i_pixel.green;
        if (i_pixel.blue > hi_val) hi_val = i_pixel.blue;
        lo_val = i_pixel.red;
        if (i_pixel.green < lo_val) lo_val = i_pixel.green;
        if (i_pixel.blue < lo_val) lo_val = i_pixel.blue;
        dlt   = hi_val - lo_val;
        red_x = SECT_W'(i_pixel.red);
        grn_x = SECT_W'(i_pixel.green);
        blu_x = SECT_W'(i_pixel.blue);
        dlt_x = SECT_W'(dlt);

        n_job.hi    = hi_val;
        n_job.delta = dlt;
        n_job.undef = (dlt == '0);
        n_job.neg   = 1'b0;
        if (i_pixel.red == hi_val) begin
            if (i_pixel.green >= i_pixel.blue) begin
                n_job.num = grn_x - blu_x;
            end else begin
                n_job.num = blu_x - grn_x;
                n_job.neg = 1'b1;
            end
        end else if (i_pixel.green == hi_val) begin
            n_job.num = (dlt_x << 1) + blu_x - red_x;
        end else begin
            n_job.num = (dlt_x << 2) + red_x - grn_x;
        end
    end

    always_comb begin
        if (i_take) begin
            n_valid = 1'b1;
        end else if (i_q_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_job <= n_job;
        end
    end

    assign o_busy = r_valid & ~i_q_ready;
    assign o_push = r_valid & i_q_ready;
    assign o_job  = r_job;

endmodule
`default_nettype wire

// ----- sv/rgbhsv_queue.sv -----
// Short job queue between front and back end.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsv_queue import rgbhsv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_ready,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_slot[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ----- sv/rgbhsv_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit QUO_W bits. Depends on rgbhsv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsv_div import rgbhsv_pkg::*; (
    input  logic                    i_clk,
    input  logic [NUM_W-1:0]        i_num,
    input  logic [CHANNEL_BITS-1:0] i_den,
    output logic [QUO_W-1:0]        o_quo
);

    logic [CHANNEL_BITS-1:0] r_rem [QUO_W+1];
    logic [CHANNEL_BITS-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0]        r_low [QUO_W+1];
    logic [QUO_W-1:0]        r_quo [QUO_W+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num[NUM_W-1:QUO_W];
        r_low[0] <= i_num[QUO_W-1:0];
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_step
        logic [CHANNEL_BITS:0]   trial;
        logic [CHANNEL_BITS:0]   diff;
        logic                    ge;
        logic [CHANNEL_BITS-1:0] n_rem;

        assign trial = {r_rem[s-1], r_low[s-1][QUO_W-1]};
        assign ge    = (trial >= {1'b0, r_den[s-1]});
        assign diff  = trial - {1'b0, r_den[s-1]};
        assign n_rem = ge ? diff[CHANNEL_BITS-1:0] : trial[CHANNEL_BITS-1:0];

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_den[s] <= r_den[s-1];
            r_low[s] <= {r_low[s-1][QUO_W-2:0], 1'b0};
            r_quo[s] <= {r_quo[s-1][QUO_W-2:0], ge};
        end
    end

    assign o_quo = r_quo[QUO_W];

endmodule
`default_nettype wire

// ----- sv/rgbhsv_back.sv -----
// Back end: forms hue and saturation numerators, runs both divisions
// and finishes the result. Depends on rgbhsv_pkg and rgbhsv_div.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsv_back import rgbhsv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_job i_job,
    output logic o_pop,
    output logic o_valid,
    output t_hsv o_result
);

    logic                    r_p_valid;
    logic [NUM_W-1:0]        r_hue_num;
    logic [NUM_W-1:0]        r_sat_num;
    logic [CHANNEL_BITS-1:0] r_delta;
    t_side                   r_p_side;
    logic                    r_sv   [QUO_W+1];
    t_side                   r_side [QUO_W+1];
    logic [QUO_W-1:0]        hue_q;
    logic [QUO_W-1:0]        sat_q;
    logic                    r_done;
    t_hsv                    r_out;
    t_hsv                    n_out;
    logic [SECT_W+SIXTY_W-1:0]   hue_prod;
    logic [2*CHANNEL_BITS-1:0]   sat_prod;
    logic [HUE_W-1:0]            hue_mag;
    logic [HUE_W-1:0]            full_turn;

    assign o_pop    = i_valid;
    assign hue_prod = (SECT_W+SIXTY_W)'(i_job.num) * (SECT_W+SIXTY_W)'(SIXTY_UNITS);
    assign sat_prod = {i_job.delta, {CHANNEL_BITS{1'b0}}} - (2*CHANNEL_BITS)'(i_job.delta);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue_num         <= NUM_W'(hue_prod);
        r_sat_num         <= NUM_W'(sat_prod);
        r_delta           <= i_job.delta;
        r_p_side.hi       <= i_job.hi;
        r_p_side.neg      <= i_job.neg;
        r_p_side.undef    <= i_job.undef;
    end

    rgbhsv_div u_hue_div (
        .i_clk (i_clk),
        .i_num (r_hue_num),
        .i_den (r_delta),
        .o_quo (hue_q)
    );

    rgbhsv_div u_sat_div (
        .i_clk (i_clk),
        .i_num (r_sat_num),
        .i_den (r_p_side.hi),
        .o_quo (sat_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else begin
            r_sv[0] <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= r_p_side;
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s] <= 1'b0;
            end else begin
                r_sv[s] <= r_sv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[s] <= r_side[s-1];
        end
    end

    assign hue_mag   = hue_q[HUE_W-1:0];
    assign full_turn = HUE_W'(FULL_TURN_UNITS);

    always_comb begin
        n_out.brightness    = r_side[QUO_W].hi;
        n_out.hue_undefined = r_side[QUO_W].undef;
        if (r_side[QUO_W].hi == '0) begin
            n_out.saturation = '0;
        end else begin
            n_out.saturation = sat_q[CHANNEL_BITS-1:0];
        end
        if (r_side[QUO_W].undef) begin
            n_out.hue = '0;
        end else if (r_side[QUO_W].neg) begin
            n_out.hue = (hue_mag == '0) ? '0 : full_turn - hue_mag;
        end else begin
            n_out.hue = hue_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_sv[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_done;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ----- sv/rgb_to_hsv_converter.sv -----
// Top level of the RGB to HSV converter: front end, job queue, back end.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_queue, rgbhsv_back.
//
//   channel   ports                   handshake
//   pixel in  start, busy, i_pixel    taken when start high and busy low
//   result    o_valid, o_result       one cycle per result, no backpressure
//
// One pixel per clock; busy stays low since the back end drains the queue
// every cycle. Latency is set by the two bit-per-stage division pipelines
// for hue and saturation.
// Reset is synchronous and clears only valid and queue state.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsv_converter import rgbhsv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_pixel i_pixel,
    output logic   o_valid,
    output t_hsv   o_result
);

    logic take;
    logic q_ready;
    logic q_valid;
    logic push;
    logic pop;
    t_job front_job;
    t_job q_job;

    assign take = start & ~busy;

    rgbhsv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_pixel   (i_pixel),
        .i_q_ready (q_ready),
        .o_busy    (busy),
        .o_push    (push),
        .o_job     (front_job)
    );

    rgbhsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    rgbhsv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (q_job),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ----- sim/rgb_to_hsv_converter_test.sv -----
// Self-checking testbench for rgb_to_hsv_converter: directed and random pixels,
// with the expected HSV computed alongside. Depends on rgbhsv_pkg and the
// converter RTL.
`timescale 1ns / 1ps
module rgb_to_hsv_converter_test;
    import rgbhsv_pkg::*;

    localparam logic [CHANNEL_BITS-1:0] CHAN_FULL = '1;
    localparam int DRAIN_CYCLES = QUO_W + 15;
    localparam int RANDOM_PER_PHASE = 175;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_pixel i_pixel = '0;
    logic   o_valid;
    t_hsv   o_result;

    t_hsv hsv_expected[$];
    int   error_count = 0;
    int   pixels_sent = 0;
    int   results_checked = 0;
    int   idle_pct = 0;

    rgb_to_hsv_converter u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pixel  (i_pixel),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_hsv predict_hsv(input t_pixel px);
        logic [63:0] r, g, b, hi, lo, delta, hue, sat, mag, num;
        logic        undef;
        t_hsv        res;
        r = 64'(px.red);
        g = 64'(px.green);
        b = 64'(px.blue);
        hi = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        delta = hi - lo;
        hue = '0;
        sat = '0;
        undef = 1'b0;
        if (hi != 0) sat = (delta * 64'(CHAN_FULL)) / hi;
        if (delta == 0) begin
            undef = 1'b1;
        end else if (r == hi) begin
            if (g >= b) begin
                hue = ((g - b) * 64'(SIXTY_UNITS)) / delta;
            end else begin
                mag = ((b - g) * 64'(SIXTY_UNITS)) / delta;
                if (mag != 0) hue = 64'(FULL_TURN_UNITS) - mag;
            end
        end else if (g == hi) begin
            num = 2 * delta + b - r;
            hue = (num * 64'(SIXTY_UNITS)) / delta;
        end else begin
            num = 4 * delta + r - g;
            hue = (num * 64'(SIXTY_UNITS)) / delta;
        end
        res.hue           = hue[HUE_W-1:0];
        res.hue_undefined = undef;
        res.saturation    = sat[CHANNEL_BITS-1:0];
        res.brightness    = hi[CHANNEL_BITS-1:0];
        return res;
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] random_channel();
        return CHANNEL_BITS'($urandom());
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel                  px;
        logic [CHANNEL_BITS-1:0] base;
        int                      pick;
        px.red   = random_channel();
        px.green = random_channel();
        px.blue  = random_channel();
        base = random_channel();
        pick = $urandom_range(3);
        case ($urandom_range(9))
            4: begin
                if ($urandom_range(1)) px.red = '0; else px.red = CHAN_FULL;
                if ($urandom_range(1)) px.green = CHAN_FULL;
                if ($urandom_range(1)) px.blue = '0;
            end
            5: begin
                if (pick == 0) begin
                    px.red = base;
                    px.green = base;
                end else if (pick == 1) begin
                    px.green = base;
                    px.blue = base;
                end else begin
                    px.red = base;
                    px.blue = base;
                end
            end
            6: begin
                if (base < CHANNEL_BITS'(4)) base = CHANNEL_BITS'(4);
                if (base > CHAN_FULL - CHANNEL_BITS'(4)) base = CHAN_FULL - CHANNEL_BITS'(4);
                px.red   = base + CHANNEL_BITS'($urandom_range(8)) - CHANNEL_BITS'(4);
                px.green = base + CHANNEL_BITS'($urandom_range(8)) - CHANNEL_BITS'(4);
                px.blue  = base + CHANNEL_BITS'($urandom_range(8)) - CHANNEL_BITS'(4);
            end
            7: begin
                px.red = base;
                px.green = base;
                px.blue = base;
            end
            8: begin
                px.red   = CHANNEL_BITS'($urandom_range(3));
                px.green = CHANNEL_BITS'($urandom_range(3));
                px.blue  = CHANNEL_BITS'($urandom_range(3));
                if (pick == 0) px.red = CHAN_FULL;
                else if (pick == 1) px.green = CHAN_FULL;
                else if (pick == 2) px.blue = CHAN_FULL;
            end
            9: begin
                px.red   = CHANNEL_BITS'($urandom_range(3));
                px.green = CHANNEL_BITS'($urandom_range(3));
                px.blue  = CHANNEL_BITS'($urandom_range(3));
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < 30)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < idle_pct) begin
            start   <= 1'b0;
            i_pixel <= random_pixel();
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        hsv_expected.push_back(predict_hsv(px));
        pixels_sent++;
    endtask

    task automatic send_rgb(input int r, input int g, input int b);
        t_pixel px;
        px.red   = CHANNEL_BITS'(r);
        px.green = CHANNEL_BITS'(g);
        px.blue  = CHANNEL_BITS'(b);
        send_pixel(px);
    endtask

    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n && o_valid) begin
            if (hsv_expected.size() == 0) begin
                report_mismatch("unexpected result, hue", o_result.hue, 0);
            end else begin
                want = hsv_expected.pop_front();
                results_checked++;
                if (o_result.hue !== want.hue)
                    report_mismatch("hue", o_result.hue, want.hue);
                if (o_result.hue_undefined !== want.hue_undefined)
                    report_mismatch("hue_undefined", o_result.hue_undefined,
                                    want.hue_undefined);
                if (o_result.saturation !== want.saturation)
                    report_mismatch("saturation", o_result.saturation, want.saturation);
                if (o_result.brightness !== want.brightness)
                    report_mismatch("brightness", o_result.brightness, want.brightness);
            end
        end
    end

    task automatic test_black_and_grey();
        send_rgb(0, 0, 0);
        send_rgb(65535, 65535, 65535);
        send_rgb(1, 1, 1);
        send_rgb(32768, 32768, 32768);
    endtask

    task automatic test_primary_sectors();
        send_rgb(65535, 0, 0);
        send_rgb(0, 65535, 0);
        send_rgb(0, 0, 65535);
        send_rgb(1, 0, 0);
        send_rgb(0, 0, 1);
        send_rgb(40000, 10000, 30000);
        send_rgb(10000, 40000, 30000);
        send_rgb(30000, 10000, 40000);
    endtask

    task automatic test_sector_ties();
        send_rgb(65535, 65535, 0);
        send_rgb(0, 65535, 65535);
        send_rgb(65535, 0, 65535);
        send_rgb(500, 500, 499);
        send_rgb(500, 499, 500);
        send_rgb(499, 500, 500);
    endtask

    task automatic test_small_negative_hue();
        send_rgb(65535, 0, 1);
        send_rgb(65535, 65534, 65535);
        send_rgb(65535, 1, 2);
        send_rgb(65535, 65534, 65534);
        send_rgb(2, 0, 1);
    endtask

    task automatic test_random_pixels(input int count, input int pct);
        idle_pct = pct;
        repeat (count) send_pixel(random_pixel());
        idle_pct = 0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_black_and_grey();
        test_primary_sectors();
        test_sector_ties();
        test_small_negative_hue();
        test_random_pixels(RANDOM_PER_PHASE, 0);
        test_random_pixels(RANDOM_PER_PHASE, 66);
        test_random_pixels(RANDOM_PER_PHASE, 0);
        test_random_pixels(RANDOM_PER_PHASE, 36);

        start <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered black, grey, primaries, sector ties, small negative hue and");
        $display("random pixels at 0/66/36%% input gaps: %0d sent, %0d checked, %0d errors",
                 pixels_sent, results_checked, error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d results still outstanding", hsv_expected.size());
        $display("tb: failure");
        $finish;
    end

endmodule
